### src/multi_axis_dda_step_generator_unit_macros.svh
// Assertion macros for the DDA step generator checker.
// Depends on nothing; included by the checker file only.
`ifndef MULTI_AXIS_DDA_STEP_GENERATOR_UNIT_MACROS_SVH
`define MULTI_AXIS_DDA_STEP_GENERATOR_UNIT_MACROS_SVH

// Check a property only while reset is released.
`define MDDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MDDA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mdda_pkg.sv
// Shared types and constants for the multi-joint DDA step generator.
// Used by mdda_joint and the top level; depends on nothing.
package mdda_pkg;

    localparam int FUNC_W      = 3;
    localparam int JOINT_W     = 3;
    localparam int STEP_W      = 32;
    localparam int RATE_W      = 17;
    localparam int ACC_W       = 16;
    localparam int LANE_W      = 6;
    localparam int NUM_JOINTS  = 6;
    localparam int JOINT_SPAN  = 1 << JOINT_W;

    // One full step in Q16
    localparam logic [RATE_W-1:0] ONE_STEP = RATE_W'(1 << ACC_W);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_SET_TARGET = 3'd1,
        FUNC_SET_RATE   = 3'd2,
        FUNC_SET_POS    = 3'd3,
        FUNC_HALT       = 3'd4,
        FUNC_READ       = 3'd5
    } t_func;

    // Command item as held in the input register
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [JOINT_W-1:0]       joint;
        logic signed [STEP_W-1:0] steps;
        logic [RATE_W-1:0]        rate;
    } t_item;

    // Command as seen by one joint lane
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     hit;
        logic signed [STEP_W-1:0] steps;
        logic [RATE_W-1:0]        rate;
    } t_joint_cmd;

    // Next-state view that a joint lane reports back
    typedef struct packed {
        logic                     step;
        logic                     dir;
        logic signed [STEP_W-1:0] pos;
    } t_joint_stat;

endpackage

### src/mdda_joint.sv
// One joint lane: phase accumulator, rate, target, position and direction.
// Depends on mdda_pkg.
module mdda_joint (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_invert,
    input  mdda_pkg::t_joint_cmd i_cmd,
    output mdda_pkg::t_joint_stat o_stat
);
    import mdda_pkg::*;

    logic [ACC_W-1:0]         r_acc,  n_acc;
    logic [RATE_W-1:0]        r_rate, n_rate;
    logic signed [STEP_W-1:0] r_tgt,  n_tgt;
    logic signed [STEP_W-1:0] r_pos,  n_pos;
    logic                     r_dir,  n_dir;
    logic                     step;
    logic [RATE_W-1:0]        sum;
    logic                     fwd;

    assign sum = RATE_W'(r_acc) + r_rate;
    assign fwd = r_tgt > r_pos;

    // Decode the command against this joint's state
    always_comb begin
        n_acc  = r_acc;
        n_rate = r_rate;
        n_tgt  = r_tgt;
        n_pos  = r_pos;
        n_dir  = r_dir;
        step   = 1'b0;
        case (t_func'(i_cmd.func))
            FUNC_TICK: begin
                n_acc = sum[ACC_W-1:0];
                if (sum[ACC_W] && (r_tgt != r_pos)) begin
                    step  = 1'b1;
                    n_dir = fwd ^ i_invert;
                    n_pos = fwd ? r_pos + STEP_W'(1) : r_pos - STEP_W'(1);
                end
            end
            FUNC_SET_TARGET: begin
                if (i_cmd.hit) n_tgt = i_cmd.steps;
            end
            FUNC_SET_RATE: begin
                if (i_cmd.hit) n_rate = i_cmd.rate;
            end
            FUNC_SET_POS: begin
                if (i_cmd.hit) begin
                    n_tgt = i_cmd.steps;
                    n_pos = i_cmd.steps;
                end
            end
            FUNC_HALT: begin
                n_tgt = r_pos;
            end
            default: begin
            end
        endcase
    end

    // Commit the lane state when the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_rate <= '0;
            r_tgt  <= '0;
            r_pos  <= '0;
            r_dir  <= 1'b0;
        end else if (i_en) begin
            r_acc  <= n_acc;
            r_rate <= n_rate;
            r_tgt  <= n_tgt;
            r_pos  <= n_pos;
            r_dir  <= n_dir;
        end
    end

    assign o_stat.step = step;
    assign o_stat.dir  = n_dir;
    assign o_stat.pos  = n_pos;

endmodule

### src/multi_axis_dda_step_generator_unit.sv
// Multi-joint DDA step pulse generator, top level.
// Path: each item passes the input register, then the result register.
// Throughput: one item per cycle while the result channel is not stalled; every joint lane updates in parallel.
// Reset (i_rst_n low, synchronous): all joint state, the invert mask and both valids clear.
// Depends on mdda_pkg and mdda_joint.
module multi_axis_dda_step_generator_unit #(
    parameter int P_NUM_JOINTS = mdda_pkg::NUM_JOINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mdda_pkg::FUNC_W-1:0]         i_func,
    input  logic [mdda_pkg::JOINT_W-1:0]        i_joint,
    input  logic signed [mdda_pkg::STEP_W-1:0]  i_steps,
    input  logic [mdda_pkg::RATE_W-1:0]         i_rate_per_tick,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mdda_pkg::LANE_W-1:0]         o_step_pulses,
    output logic [mdda_pkg::LANE_W-1:0]         o_dir_levels,
    output logic signed [mdda_pkg::STEP_W-1:0]  o_position,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mdda_pkg::LANE_W-1:0]         i_cfg_invert_mask
);
    import mdda_pkg::*;

    logic                     r_in_vld;
    t_item                    r_in;
    logic                     r_out_vld;
    logic [LANE_W-1:0]        r_pulses, n_pulses;
    logic [LANE_W-1:0]        r_dirs,   n_dirs;
    logic signed [STEP_W-1:0] r_pos,    n_pos;
    logic [LANE_W-1:0]        r_inv;
    logic                     adv;
    logic                     in_xfer;
    logic [RATE_W-1:0]        rate_sat;
    t_joint_cmd               cmd_base;
    t_joint_stat              stat [P_NUM_JOINTS];
    logic [P_NUM_JOINTS-1:0]  hit;

    // Move the held item forward when the result register is free or drains
    assign adv         = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready     = !r_in_vld || adv;
    assign in_xfer     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.func  <= i_func;
            r_in.joint <= i_joint;
            r_in.steps <= i_steps;
            r_in.rate  <= i_rate_per_tick;
        end
    end

    // Hold the direction inversion mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= '0;
        end else if (i_cfg_valid) begin
            r_inv <= i_cfg_invert_mask;
        end
    end

    // Saturate the rate to one step per tick
    assign rate_sat = (r_in.rate > ONE_STEP) ? ONE_STEP : r_in.rate;

    assign cmd_base.func  = r_in.func;
    assign cmd_base.hit   = 1'b0;
    assign cmd_base.steps = r_in.steps;
    assign cmd_base.rate  = rate_sat;

    // Joint lanes
    for (genvar j = 0; j < P_NUM_JOINTS; j++) begin : g_joint
        t_joint_cmd cmd;
        logic       inv_bit;

        if (j < JOINT_SPAN) begin : g_hit
            assign hit[j] = (r_in.joint == JOINT_W'(j));
        end else begin : g_nohit
            assign hit[j] = 1'b0;
        end

        if (j < LANE_W) begin : g_inv
            assign inv_bit = r_inv[j];
        end else begin : g_noinv
            assign inv_bit = 1'b0;
        end

        always_comb begin
            cmd     = cmd_base;
            cmd.hit = hit[j];
        end

        mdda_joint u_joint (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_invert (inv_bit),
            .i_cmd    (cmd),
            .o_stat   (stat[j])
        );
    end

    // Gather pulses, levels and the selected position
    always_comb begin
        n_pulses = '0;
        n_dirs   = '0;
        n_pos    = '0;
        for (int k = 0; k < P_NUM_JOINTS; k++) begin
            if (k < LANE_W) begin
                n_pulses[k] = stat[k].step;
                n_dirs[k]   = stat[k].dir;
            end
            if (hit[k]) begin
                n_pos = stat[k].pos;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pulses <= n_pulses;
            r_dirs   <= n_dirs;
            r_pos    <= n_pos;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_step_pulses = r_pulses;
    assign o_dir_levels  = r_dirs;
    assign o_position    = r_pos;

endmodule

### src/mdda_checker.sv
// Port-level checker for the DDA step generator, bound to the top level.
// Depends on mdda_pkg and the macro header.
`include "multi_axis_dda_step_generator_unit_macros.svh"

module mdda_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [mdda_pkg::LANE_W-1:0]         i_step_pulses,
    input logic signed [mdda_pkg::STEP_W-1:0]  i_position
);
    import mdda_pkg::*;

    // A stalled result stays offered
    `MDDA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `MDDA_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_position) && $stable(i_step_pulses), "result changed while stalled")

    // Reset empties the result register
    `MDDA_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // With both registers full and no drain, stop taking commands
    `MDDA_ASSERT(a_backpressure, i_clk, i_rst_n, (i_out_valid && !i_out_ready && i_in_valid && i_in_ready) ##1 !i_out_ready |-> !i_in_ready, "command taken with both stages full")

endmodule

bind multi_axis_dda_step_generator_unit mdda_checker u_mdda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_valid),
    .i_in_ready    (o_ready),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_step_pulses (o_step_pulses),
    .i_position    (o_position)
);
